/* src/rc4kd_pkg.sv */
package rc4kd_pkg;

   // box geometry
   localparam int BOX_DEPTH = 256;
   localparam int BOX_AW    = 8;
   localparam int BYTE_W    = 8;

   // item kinds on the request channel
   localparam logic REQ_KEY  = 1'b0;
   localparam logic REQ_DATA = 1'b1;

   // control sequencer, one-hot
   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,
      ST_D_B  = 10'b00_0000_0010,
      ST_D_C  = 10'b00_0000_0100,
      ST_D_K  = 10'b00_0000_1000,
      ST_OUT  = 10'b00_0001_0000,
      ST_INIT = 10'b00_0010_0000,
      ST_RD_I = 10'b00_0100_0000,
      ST_RD_J = 10'b00_1000_0000,
      ST_WR_I = 10'b01_0000_0000,
      ST_WR_J = 10'b10_0000_0000
   } state_type;

   // write request into the box memory
   typedef struct packed {
      logic              en;
      logic [BOX_AW-1:0] addr;
      logic [BYTE_W-1:0] data;
   } box_wr_type;

endpackage

/* src/rc4kd_box_ram.sv */
module rc4kd_box_ram (
   input  logic                            clock,
   input  rc4kd_pkg::box_wr_type           wr,
   input  logic [rc4kd_pkg::BOX_AW-1:0]    rd_addr,
   output logic [rc4kd_pkg::BYTE_W-1:0]    rd_data
);

   logic [rc4kd_pkg::BYTE_W-1:0] mem [rc4kd_pkg::BOX_DEPTH];
   logic [rc4kd_pkg::BYTE_W-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/rc4_box_keystream_decryptor.sv */
// Data item, box keyed: runs through D_B, D_C, D_K and OUT, and req_stall stays high until it leaves OUT
//   (three dependent reads through the one box read port, then the output register).
// Data item before any key: goes straight to OUT unchanged, with req_stall high until it leaves OUT.
// Last key byte: key schedule (identity fill, then a read-read-write-write swap per entry) with req_stall high.
// Synchronous active-high reset clears control state; box and key store are
//   left undefined and are always written before being read.
module rc4_box_keystream_decryptor #(
   parameter int KEY_MAX = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_type,
   input  logic [rc4kd_pkg::BYTE_W-1:0]   req_in_value,
   input  logic                           req_last_key,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rc4kd_pkg::BYTE_W-1:0]   rsp_out_byte
);

   localparam int CNT_W  = $clog2(KEY_MAX + 1);
   localparam int KIDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

   rc4kd_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]                key_count_ff, key_count_in;
   logic [KIDX_W-1:0]               kidx_ff, kidx_in;
   logic [rc4kd_pkg::BOX_AW-1:0]    stream_pos_ff, stream_pos_in;
   logic                            keyed_ff, keyed_in;
   logic [rc4kd_pkg::BOX_AW-1:0]    i_ff, i_in;
   logic [rc4kd_pkg::BOX_AW-1:0]    acc_ff, acc_in;
   logic [rc4kd_pkg::BYTE_W-1:0]    held_ff, held_in;
   logic [rc4kd_pkg::BYTE_W-1:0]    a_ff, a_in;
   logic [rc4kd_pkg::BYTE_W-1:0]    data_ff, data_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [rc4kd_pkg::BYTE_W-1:0]    rsp_byte_ff, rsp_byte_in;

   logic                            req_take;
   logic                            key_wr_en;
   logic [rc4kd_pkg::BYTE_W-1:0]    key_mem [KEY_MAX];
   logic [rc4kd_pkg::BYTE_W-1:0]    key_rd_ff;
   logic [rc4kd_pkg::BOX_AW-1:0]    box_rd_addr;
   logic [rc4kd_pkg::BYTE_W-1:0]    box_rd;
   logic [rc4kd_pkg::BYTE_W-1:0]    sum_acc;
   logic [CNT_W-1:0]                kidx_next;
   rc4kd_pkg::box_wr_type           box_wr;

   assign req_stall    = (state_ff != rc4kd_pkg::ST_IDLE);
   assign req_take     = req_valid && !req_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

   // key store: written on accepted key bytes while it has room, read by the schedule
   assign key_wr_en = req_take && (req_type == rc4kd_pkg::REQ_KEY)
                      && (key_count_ff < CNT_W'(KEY_MAX));

   always_ff @(posedge clock) begin
      if (key_wr_en) begin
         key_mem[key_count_ff[KIDX_W-1:0]] <= req_in_value;
      end
      key_rd_ff <= key_mem[kidx_ff];
   end

   // permutation box
   rc4kd_box_ram u_box (
      .clock   (clock),
      .wr      (box_wr),
      .rd_addr (box_rd_addr),
      .rd_data (box_rd)
   );

   // schedule accumulator and cycling key index
   assign sum_acc   = acc_ff + box_rd + key_rd_ff;
   assign kidx_next = CNT_W'(kidx_ff) + CNT_W'(1);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      key_count_in  = key_count_ff;
      kidx_in       = kidx_ff;
      stream_pos_in = stream_pos_ff;
      keyed_in      = keyed_ff;
      i_in          = i_ff;
      acc_in        = acc_ff;
      held_in       = held_ff;
      a_in          = a_ff;
      data_in       = data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_byte_in   = rsp_byte_ff;
      box_rd_addr   = stream_pos_ff;
      box_wr        = '0;

      unique case (state_ff)
         rc4kd_pkg::ST_IDLE: begin
            // box at the stream position is read ahead every idle cycle
            box_rd_addr = stream_pos_ff;
            if (req_take) begin
               if (req_type == rc4kd_pkg::REQ_KEY) begin
                  if (key_wr_en) begin
                     key_count_in = key_count_ff + CNT_W'(1);
                  end
                  if (req_last_key) begin
                     i_in     = '0;
                     state_in = rc4kd_pkg::ST_INIT;
                  end
               end else begin
                  data_in  = req_in_value;
                  state_in = keyed_ff ? rc4kd_pkg::ST_D_B : rc4kd_pkg::ST_OUT;
               end
            end
         end
         rc4kd_pkg::ST_D_B: begin
            a_in        = box_rd;
            box_rd_addr = box_rd + stream_pos_ff;
            state_in    = rc4kd_pkg::ST_D_C;
         end
         rc4kd_pkg::ST_D_C: begin
            box_rd_addr = a_ff + box_rd;
            state_in    = rc4kd_pkg::ST_D_K;
         end
         rc4kd_pkg::ST_D_K: begin
            data_in       = data_ff ^ box_rd;
            stream_pos_in = stream_pos_ff + rc4kd_pkg::BOX_AW'(1);
            state_in      = rc4kd_pkg::ST_OUT;
         end
         rc4kd_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = data_ff;
               state_in     = rc4kd_pkg::ST_IDLE;
            end
         end
         rc4kd_pkg::ST_INIT: begin
            // identity fill
            box_wr = '{en: 1'b1, addr: i_ff, data: i_ff};
            i_in   = i_ff + rc4kd_pkg::BOX_AW'(1);
            if (i_ff == rc4kd_pkg::BOX_AW'(rc4kd_pkg::BOX_DEPTH - 1)) begin
               acc_in   = '0;
               kidx_in  = '0;
               state_in = rc4kd_pkg::ST_RD_I;
            end
         end
         rc4kd_pkg::ST_RD_I: begin
            box_rd_addr = i_ff;
            state_in    = rc4kd_pkg::ST_RD_J;
         end
         rc4kd_pkg::ST_RD_J: begin
            held_in     = box_rd;
            acc_in      = sum_acc;
            box_rd_addr = sum_acc;
            state_in    = rc4kd_pkg::ST_WR_I;
         end
         rc4kd_pkg::ST_WR_I: begin
            box_wr   = '{en: 1'b1, addr: i_ff, data: box_rd};
            state_in = rc4kd_pkg::ST_WR_J;
         end
         rc4kd_pkg::ST_WR_J: begin
            box_wr  = '{en: 1'b1, addr: acc_ff, data: held_ff};
            i_in    = i_ff + rc4kd_pkg::BOX_AW'(1);
            kidx_in = (kidx_next >= key_count_ff) ? '0 : kidx_next[KIDX_W-1:0];
            if (i_ff == rc4kd_pkg::BOX_AW'(rc4kd_pkg::BOX_DEPTH - 1)) begin
               key_count_in  = '0;
               stream_pos_in = rc4kd_pkg::BOX_AW'(1);
               keyed_in      = 1'b1;
               state_in      = rc4kd_pkg::ST_IDLE;
            end else begin
               state_in = rc4kd_pkg::ST_RD_I;
            end
         end
         default: begin
            state_in = rc4kd_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rc4kd_pkg::ST_IDLE;
         key_count_ff  <= '0;
         stream_pos_ff <= rc4kd_pkg::BOX_AW'(1);
         keyed_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         key_count_ff  <= key_count_in;
         stream_pos_ff <= stream_pos_in;
         keyed_ff      <= keyed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kidx_ff     <= kidx_in;
      i_ff        <= i_in;
      acc_ff      <= acc_in;
      held_ff     <= held_in;
      a_ff        <= a_in;
      data_ff     <= data_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   // the box is never written while a data item is being worked
   a_no_box_wr_on_data: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rc4kd_pkg::ST_D_B || state_ff == rc4kd_pkg::ST_D_C ||
       state_ff == rc4kd_pkg::ST_D_K || state_ff == rc4kd_pkg::ST_OUT) |-> !box_wr.en)
      else $error("box write during data item");

   // key count stays within the store
   a_key_count_range: assert property (@(posedge clock) disable iff (reset)
      key_count_ff <= CNT_W'(KEY_MAX))
      else $error("key count beyond store");

   // end of schedule leaves a clean stream start
   a_sched_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rc4kd_pkg::ST_WR_J && i_ff == rc4kd_pkg::BOX_AW'(rc4kd_pkg::BOX_DEPTH - 1))
      |=> keyed_ff && key_count_ff == '0 && stream_pos_ff == rc4kd_pkg::BOX_AW'(1))
      else $error("schedule end state wrong");

   // stream position moves only on a keystream byte or a schedule end
   a_pos_moves: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(stream_pos_ff)) |->
      ($past(state_ff) == rc4kd_pkg::ST_D_K || $past(state_ff) == rc4kd_pkg::ST_WR_J))
      else $error("stream position moved unexpectedly");

   // a new result is only loaded from the output state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall) |=> (!rsp_valid_ff || $past(state_ff) == rc4kd_pkg::ST_OUT))
      else $error("result without a finished item");

endmodule

/* tb/rc4_box_keystream_decryptor_tb.sv */
module rc4_box_keystream_decryptor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KEY_DEPTH = 128;

   // what leads off each traffic phase
   typedef enum int {
      OPEN_KEY_OVERFLOW,
      OPEN_KEY_FULL,
      OPEN_LONG_STREAM
   } opener_type;

   // keystream predictor and queue of expected plaintext bytes
   class keystream_scoreboard;
      bit [rc4kd_pkg::BYTE_W-1:0] key_bytes [KEY_DEPTH];
      int                         key_len;
      bit [rc4kd_pkg::BYTE_W-1:0] sbox [rc4kd_pkg::BOX_DEPTH];
      bit [rc4kd_pkg::BYTE_W-1:0] pos;
      bit                         keyed;
      bit [rc4kd_pkg::BYTE_W-1:0] plain_q [$];
      int                         errors;
      int                         checked;
      int                         n_key;
      int                         n_data;
      int                         n_sched;

      function new();
         key_len = 0;
         pos     = 8'd1;
         keyed   = 1'b0;
         errors  = 0;
         checked = 0;
         n_key   = 0;
         n_data  = 0;
         n_sched = 0;
      endfunction

      // standard key schedule, key cycled over the bytes held
      function void schedule_box();
         bit [rc4kd_pkg::BYTE_W-1:0] acc;
         bit [rc4kd_pkg::BYTE_W-1:0] held;
         int                         kidx;
         acc  = '0;
         kidx = 0;
         for (int i = 0; i < rc4kd_pkg::BOX_DEPTH; i++) sbox[i] = i[rc4kd_pkg::BYTE_W-1:0];
         for (int i = 0; i < rc4kd_pkg::BOX_DEPTH; i++) begin
            held = sbox[i];
            acc = acc + held + key_bytes[kidx];
            sbox[i] = sbox[acc];
            sbox[acc] = held;
            kidx++;
            if (kidx >= key_len) kidx = 0;
         end
         key_len = 0;
         pos     = 8'd1;
         keyed   = 1'b1;
         n_sched++;
      endfunction

      function void note_input(logic kind, logic [rc4kd_pkg::BYTE_W-1:0] value, logic last);
         bit [rc4kd_pkg::BYTE_W-1:0] a;
         bit [rc4kd_pkg::BYTE_W-1:0] b;
         bit [rc4kd_pkg::BYTE_W-1:0] idx;
         if (kind == rc4kd_pkg::REQ_KEY) begin
            n_key++;
            // bytes past the store are dropped, last flag still counts
            if (key_len < KEY_DEPTH) begin
               key_bytes[key_len] = value;
               key_len++;
            end
            if (last) schedule_box();
         end else begin
            n_data++;
            if (!keyed) begin
               plain_q.insert(plain_q.size(), value);
            end else begin
               a   = sbox[pos];
               idx = a + pos;
               b   = sbox[idx];
               idx = a + b;
               plain_q.insert(plain_q.size(), value ^ sbox[idx]);
               pos = pos + 8'd1;
            end
         end
      endfunction

      function void check_result(logic [rc4kd_pkg::BYTE_W-1:0] got);
         bit [rc4kd_pkg::BYTE_W-1:0] want;
         if (plain_q.size() == 0) begin
            $error("out_byte: expected nothing, actual %h", got);
            errors++;
         end else begin
            want = plain_q.pop_front();
            checked++;
            if (got !== want) begin
               $error("out_byte: expected %h, actual %h", want, got);
               errors++;
            end
         end
      endfunction
   endclass

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_type = rc4kd_pkg::REQ_KEY;
   logic [rc4kd_pkg::BYTE_W-1:0] req_in_value = '0;
   logic                         req_last_key = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [rc4kd_pkg::BYTE_W-1:0] rsp_out_byte;

   int send_idle_pct  = 13;
   int recv_stall_pct = 72;
   int n_sent = 0;

   keystream_scoreboard sb = new();

   rc4_box_keystream_decryptor #(
      .KEY_MAX(KEY_DEPTH)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_in_value (req_in_value),
      .req_last_key (req_last_key),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // receiver backpressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // result check
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_out_byte);
   end

   // one item on the request channel; entered and left at a falling edge
   task automatic send_item(logic kind, logic [rc4kd_pkg::BYTE_W-1:0] value, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_in_value <= value;
      req_last_key <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_input(kind, value, last);
      n_sent++;
      @(negedge clock);
   endtask

   task automatic send_key(int len, bit finish);
      for (int i = 0; i < len; i++)
         send_item(rc4kd_pkg::REQ_KEY, rc4kd_pkg::BYTE_W'($urandom_range(255)),
                   finish && (i == len - 1));
   endtask

   // data bytes, now and then with a stray last flag
   task automatic send_data(int len);
      for (int i = 0; i < len; i++)
         send_item(rc4kd_pkg::REQ_DATA, rc4kd_pkg::BYTE_W'($urandom_range(255)),
                   ($urandom_range(7) == 0));
   endtask

   task automatic run_traffic(int budget, opener_type opener);
      int stop_at;
      int r;
      stop_at = n_sent + budget;
      case (opener)
         OPEN_KEY_OVERFLOW: begin
            send_key(KEY_DEPTH + $urandom_range(1, 6), 1'b1);
            send_data($urandom_range(10, 30));
         end
         OPEN_KEY_FULL: begin
            send_key(KEY_DEPTH, 1'b1);
            send_data($urandom_range(10, 30));
         end
         OPEN_LONG_STREAM: begin
            send_key($urandom_range(1, 16), 1'b1);
            send_data($urandom_range(260, 300));
         end
         default: ;
      endcase
      while (n_sent < stop_at) begin
         r = $urandom_range(99);
         if (r < 70) begin
            // well-formed key then a burst of data
            send_key(($urandom_range(9) == 0) ? $urandom_range(17, KEY_DEPTH)
                                              : $urandom_range(1, 16), 1'b1);
            send_data(($urandom_range(15) == 0) ? $urandom_range(256, 300)
                                                : $urandom_range(1, 40));
         end else if (r < 85) begin
            // key left open, data still on the old box
            send_key($urandom_range(1, 6), 1'b0);
            send_data($urandom_range(1, 12));
         end else begin
            send_item(1'($urandom_range(1)), rc4kd_pkg::BYTE_W'($urandom_range(255)),
                      1'($urandom_range(1)));
         end
      end
   endtask

   // stimulus and end of run
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // data before any key passes through, stray last flag ignored
      send_item(rc4kd_pkg::REQ_DATA, 8'h00, 1'b0);
      send_item(rc4kd_pkg::REQ_DATA, 8'hff, 1'b0);
      send_item(rc4kd_pkg::REQ_DATA, 8'ha5, 1'b1);
      send_item(rc4kd_pkg::REQ_DATA, 8'h5a, 1'b0);
      // single-byte keys at the extremes
      send_item(rc4kd_pkg::REQ_KEY, 8'h00, 1'b1);
      send_item(rc4kd_pkg::REQ_DATA, 8'h00, 1'b0);
      send_item(rc4kd_pkg::REQ_DATA, 8'hff, 1'b0);
      send_item(rc4kd_pkg::REQ_KEY, 8'hff, 1'b1);
      send_item(rc4kd_pkg::REQ_DATA, 8'h3c, 1'b0);
      send_item(rc4kd_pkg::REQ_DATA, 8'hff, 1'b1);
      // new key half loaded: data keeps the old box and position
      send_item(rc4kd_pkg::REQ_KEY, 8'h80, 1'b0);
      send_item(rc4kd_pkg::REQ_DATA, 8'h11, 1'b0);
      send_item(rc4kd_pkg::REQ_DATA, 8'hee, 1'b0);
      send_item(rc4kd_pkg::REQ_KEY, 8'h01, 1'b0);
      send_item(rc4kd_pkg::REQ_KEY, 8'h7f, 1'b1);
      send_item(rc4kd_pkg::REQ_DATA, 8'h00, 1'b0);
      send_item(rc4kd_pkg::REQ_DATA, 8'h96, 1'b1);
      send_item(rc4kd_pkg::REQ_DATA, 8'h69, 1'b0);

      run_traffic(440, OPEN_KEY_OVERFLOW);

      send_idle_pct  = 72;
      recv_stall_pct = 13;
      run_traffic(440, OPEN_KEY_FULL);

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_traffic(450, OPEN_LONG_STREAM);

      req_valid <= 1'b0;
      while (sb.plain_q.size() != 0) @(posedge clock);
      // a trailing last key byte may still be scheduling
      repeat (1400) @(posedge clock);

      $display("tb: %0d items sent, %0d key bytes, %0d data bytes, %0d key schedules",
               n_sent, sb.n_key, sb.n_data, sb.n_sched);
      $display("tb: %0d decrypted bytes checked, %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
